// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SSG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SSG_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
    else $error("assertion failed");
`else
`define SSG_ASSERT(lbl, clk, rstn, prop)
`define SSG_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// File: sv/ssg_pkg.sv
// ----------------------------------------------------------------------------
// Surrogate gradient package
// Mode codes, register indexes, fixed-point constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssg_pkg;

  typedef enum logic [1:0] {
    MODE_ATAN    = 2'd0,
    MODE_SIGMOID = 2'd1,
    MODE_FAST    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 8'd1;

  localparam logic [15:0] ALPHA_RESET = 16'd512;
  localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  localparam int unsigned POT_W    = 16;
  localparam int unsigned GRAD_W   = 16;
  localparam int unsigned DSQ_W    = 57;
  localparam int unsigned Y_W      = 30;
  localparam int unsigned K_W      = 12;
  localparam int unsigned TERM_W   = 31;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned E_W      = 24;
  localparam int unsigned NUM_W    = 64;
  localparam int unsigned DIV_W    = 58;
  localparam int unsigned N_TERMS  = 10;

  typedef struct packed {
    logic             spike;
    logic [DSQ_W-1:0] dsq;
  } side_t;

endpackage

// File: sv/ssg_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Carries one membrane potential per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssg_in_if import ssg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POT_W-1:0] potential;

  modport source (output valid, output potential, input ready);
  modport sink (input valid, input potential, output ready);
endinterface

// File: sv/ssg_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Carries the spike and the surrogate gradient per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssg_out_if import ssg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              spike;
  logic [GRAD_W-1:0] surrogate_grad;

  modport source (output valid, output spike, output surrogate_grad, input ready);
  modport sink (input valid, input spike, input surrogate_grad, output ready);
endinterface

// File: sv/ssg_front.sv
// ----------------------------------------------------------------------------
// Surrogate gradient front end
// Six stages: magnitude, alpha product, squared denominator and exp argument.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssg_front import ssg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [POT_W-1:0] potential_i,
  input  mode_e                   mode_i,
  input  logic [15:0]             alpha_i,
  output logic                    valid_o,
  output logic [Y_W-1:0]          y_o,
  output logic [K_W-1:0]          k_o,
  output side_t                   side_o
);

  logic [5:0] v_q;

  logic [15:0] pot_u, mag_d, mag1_q;
  logic        spk1_q, spk2_q, spk3_q, spk4_q, spk5_q, spk6_q;
  logic [31:0] am_full;
  logic [30:0] am2_q;
  logic [47:0] pu3_q;
  logic [31:0] z_full;
  logic [26:0] z3_q;
  logic [48:0] u_full;
  logic [27:0] sel_d, sel4_q;
  logic [43:0] tz4_q;
  logic [55:0] sq;
  logic [DSQ_W-1:0] dsq5_q, dsq6_q;
  logic [44:0] t_full;
  logic [K_W-1:0] k5_q, k6_q;
  logic [15:0] f5_q;
  logic [45:0] y_full;
  logic [Y_W-1:0] y6_q;

  assign pot_u   = potential_i;
  assign mag_d   = pot_u[15] ? (~pot_u + 16'd1) : pot_u;
  assign am_full = 32'(alpha_i) * 32'(mag1_q);
  assign z_full  = 32'(am2_q) + 32'd8;
  assign u_full  = 49'(pu3_q) + 49'h8_0000;
  assign sel_d   = (mode_i == MODE_ATAN) ? u_full[47:20] : (28'h1_0000 + 28'(z3_q));
  assign sq      = 56'(sel4_q) * 56'(sel4_q);
  assign t_full  = 45'(tz4_q) + 45'h8000;
  assign y_full  = 46'(f5_q) * 46'(LN2_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag_d;
      spk1_q <= ~pot_u[15];
      am2_q  <= am_full[30:0];
      spk2_q <= spk1_q;
      pu3_q  <= 48'(am2_q) * 48'(HALF_PI_Q16);
      z3_q   <= z_full[30:4];
      spk3_q <= spk2_q;
      sel4_q <= sel_d;
      tz4_q  <= 44'(z3_q) * 44'(LOG2E_Q16);
      spk4_q <= spk3_q;
      dsq5_q <= ((mode_i == MODE_ATAN) ? 57'h1_0000_0000 : 57'd0) + 57'(sq);
      k5_q   <= t_full[43:32];
      f5_q   <= t_full[31:16];
      spk5_q <= spk4_q;
      y6_q   <= y_full[45:16];
      k6_q   <= k5_q;
      dsq6_q <= dsq5_q;
      spk6_q <= spk5_q;
    end
  end

  assign valid_o     = v_q[5];
  assign y_o         = y6_q;
  assign k_o         = k6_q;
  assign side_o.spike = spk6_q;
  assign side_o.dsq  = dsq6_q;

endmodule

// File: sv/ssg_exp.sv
// ----------------------------------------------------------------------------
// Exponential unit
// Ten Taylor terms of exp(-y), three stages each, then the power-of-two shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssg_exp import ssg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [Y_W-1:0] y_i,
  input  logic [K_W-1:0] k_i,
  input  side_t          side_i,
  output logic           valid_o,
  output logic [E_W-1:0] e_o,
  output side_t          side_o
);

  logic              v_s    [0:N_TERMS];
  logic [TERM_W-1:0] term_s [0:N_TERMS];
  logic [SUM_W-1:0]  sum_s  [0:N_TERMS];
  logic [Y_W-1:0]    y_s    [0:N_TERMS];
  logic [K_W-1:0]    k_s    [0:N_TERMS];
  side_t             side_s [0:N_TERMS];

  assign v_s[0]    = valid_i;
  assign term_s[0] = ONE_Q30;
  assign sum_s[0]  = 32'(ONE_Q30);
  assign y_s[0]    = y_i;
  assign k_s[0]    = k_i;
  assign side_s[0] = side_i;

  for (genvar j = 0; j < N_TERMS; j++) begin : g_term
    localparam int unsigned N = j + 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / N);
    localparam logic [3:0]  NC = 4'(N);
    localparam bit          ODD = (N % 2) == 1;

    logic              va_q, vb_q, vc_q;
    logic [29:0]       pa_q, pb_q, q0_q;
    logic [SUM_W-1:0]  sa_q, sb_q, sc_q;
    logic [Y_W-1:0]    ya_q, yb_q, yc_q;
    logic [K_W-1:0]    ka_q, kb_q, kc_q;
    side_t             da_q, db_q, dc_q;
    logic [TERM_W-1:0] tc_q;
    logic [60:0]       prod_a;
    logic [61:0]       prod_b;
    logic [33:0]       rem_c;
    logic [29:0]       qc;

    assign prod_a = 61'(term_s[j]) * 61'(y_s[j]);
    assign prod_b = 62'(pa_q) * 62'(RECIP);
    assign rem_c  = 34'(pb_q) - 34'(q0_q) * 34'(NC);
    assign qc     = q0_q + 30'(rem_c >= 34'(NC));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
        vc_q <= 1'b0;
      end else if (en_i) begin
        va_q <= v_s[j];
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q <= prod_a[59:30];
        sa_q <= sum_s[j];
        ya_q <= y_s[j];
        ka_q <= k_s[j];
        da_q <= side_s[j];
        q0_q <= prod_b[60:31];
        pb_q <= pa_q;
        sb_q <= sa_q;
        yb_q <= ya_q;
        kb_q <= ka_q;
        db_q <= da_q;
        tc_q <= 31'(qc);
        sc_q <= ODD ? (sb_q - 32'(qc)) : (sb_q + 32'(qc));
        yc_q <= yb_q;
        kc_q <= kb_q;
        dc_q <= db_q;
      end
    end

    assign v_s[j+1]    = vc_q;
    assign term_s[j+1] = tc_q;
    assign sum_s[j+1]  = sc_q;
    assign y_s[j+1]    = yc_q;
    assign k_s[j+1]    = kc_q;
    assign side_s[j+1] = dc_q;
  end

  logic           ve_q;
  logic [E_W-1:0] e_q, e_d;
  side_t          de_q;
  logic [4:0]     sh_amt;

  assign sh_amt = k_s[N_TERMS][4:0] + 5'd7;
  assign e_d    = (k_s[N_TERMS] >= 12'd24) ? '0 : E_W'(sum_s[N_TERMS] >> sh_amt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= v_s[N_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q  <= e_d;
      de_q <= side_s[N_TERMS];
    end
  end

  assign valid_o = ve_q;
  assign e_o     = e_q;
  assign side_o  = de_q;

  `SSG_ASSERT(a_e_bounded, clk_i, rst_ni, ve_q |-> (e_q <= 24'h80_0000))

endmodule

// File: sv/ssg_div.sv
// ----------------------------------------------------------------------------
// Gradient divider
// Forms numerator and divisor per mode, then a 16-stage restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssg_div import ssg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [E_W-1:0]    e_i,
  input  side_t             side_i,
  input  mode_e             mode_i,
  input  logic [15:0]       alpha_i,
  output logic              valid_o,
  output logic              spike_o,
  output logic [GRAD_W-1:0] quot_o
);

  logic             v1_q, v2_q;
  logic [39:0]      ae1_q;
  logic [49:0]      den1_q;
  side_t            d1_q;
  logic [24:0]      opd;
  logic [NUM_W-1:0] num_d, num2_q;
  logic [DIV_W-1:0] dv_d, dv2_q;
  logic             spk2_q;

  assign opd   = 25'h80_0000 + 25'(e_i);
  assign num_d = (mode_i == MODE_SIGMOID) ?
                 ({1'b0, ae1_q, 23'd0} + 64'(den1_q[49:1])) :
                 (64'({alpha_i, 32'd0}) + 64'(d1_q.dsq));
  assign dv_d  = (mode_i == MODE_SIGMOID) ? 58'(den1_q) : {d1_q.dsq, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ae1_q  <= 40'(alpha_i) * 40'(e_i);
      den1_q <= 50'(opd) * 50'(opd);
      d1_q   <= side_i;
      num2_q <= num_d;
      dv2_q  <= dv_d;
      spk2_q <= d1_q.spike;
    end
  end

  logic              v_s   [0:GRAD_W];
  logic [NUM_W-1:0]  rem_s [0:GRAD_W];
  logic [DIV_W-1:0]  dv_s  [0:GRAD_W];
  logic [GRAD_W-1:0] q_s   [0:GRAD_W];
  logic              sp_s  [0:GRAD_W];

  assign v_s[0]   = v2_q;
  assign rem_s[0] = num2_q;
  assign dv_s[0]  = dv2_q;
  assign q_s[0]   = '0;
  assign sp_s[0]  = spk2_q;

  for (genvar g = 0; g < GRAD_W; g++) begin : g_bit
    localparam int unsigned B = GRAD_W - 1 - g;

    logic [73:0]       dsh;
    logic              ge;
    logic              v_q, sp_q;
    logic [NUM_W-1:0]  rem_q;
    logic [DIV_W-1:0]  dv_q;
    logic [GRAD_W-1:0] q_q, q_d;

    assign dsh = 74'(dv_s[g]) << B;
    assign ge  = 74'(rem_s[g]) >= dsh;
    always_comb begin
      q_d    = q_s[g];
      q_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? (rem_s[g] - dsh[63:0]) : rem_s[g];
        dv_q  <= dv_s[g];
        q_q   <= q_d;
        sp_q  <= sp_s[g];
      end
    end

    assign v_s[g+1]   = v_q;
    assign rem_s[g+1] = rem_q;
    assign dv_s[g+1]  = dv_q;
    assign q_s[g+1]   = q_q;
    assign sp_s[g+1]  = sp_q;
  end

  assign valid_o = v_s[GRAD_W];
  assign spike_o = sp_s[GRAD_W];
  assign quot_o  = q_s[GRAD_W];

  `SSG_ASSERT(a_rem_below_div, clk_i, rst_ni, v_s[GRAD_W] |-> (rem_s[GRAD_W] < 64'(dv_s[GRAD_W])))

endmodule

// File: sv/spike_surrogate_gradient.sv
// ----------------------------------------------------------------------------
// Spike generator with surrogate gradient
// Path from input transfer to output valid: 55 pipeline stages plus the output
// register. Throughput: one item per cycle while the skid buffer is empty, set
// by the fully pipelined Taylor exponential and restoring divider stages.
// Reset clears all valid bits, mode to arctangent and alpha to 2.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spike_surrogate_gradient import ssg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ssg_in_if.sink                in_i,
  ssg_out_if.source             out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  mode_e       mode_q;
  logic [15:0] alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ATAN;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= mode_e'(cfg_data_i[1:0]);
        REG_ALPHA: alpha_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  logic           en;
  logic           s_valid_q, o_valid_q;
  logic           fr_valid, ex_valid, p_valid, p_spike;
  logic [Y_W-1:0] fr_y;
  logic [K_W-1:0] fr_k;
  side_t          fr_side, ex_side;
  logic [E_W-1:0] ex_e;
  logic [GRAD_W-1:0] p_quot, p_grad;
  logic              s_spike_q, o_spike_q;
  logic [GRAD_W-1:0] s_grad_q, o_grad_q;

  assign en       = ~s_valid_q;
  assign in_i.ready = en;

  ssg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .potential_i (in_i.potential),
    .mode_i      (mode_q),
    .alpha_i     (alpha_q),
    .valid_o     (fr_valid),
    .y_o         (fr_y),
    .k_o         (fr_k),
    .side_o      (fr_side)
  );

  ssg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .y_i     (fr_y),
    .k_i     (fr_k),
    .side_i  (fr_side),
    .valid_o (ex_valid),
    .e_o     (ex_e),
    .side_o  (ex_side)
  );

  ssg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ex_valid),
    .e_i     (ex_e),
    .side_i  (ex_side),
    .mode_i  (mode_q),
    .alpha_i (alpha_q),
    .valid_o (p_valid),
    .spike_o (p_spike),
    .quot_o  (p_quot)
  );

  assign p_grad = (mode_q == MODE_NONE) ? '0 : p_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (!o_valid_q || out_o.ready) begin
      if (s_valid_q) begin
        o_valid_q <= 1'b1;
        s_valid_q <= 1'b0;
      end else begin
        o_valid_q <= p_valid;
      end
    end else if (p_valid && en) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_valid_q || out_o.ready) begin
      if (s_valid_q) begin
        o_spike_q <= s_spike_q;
        o_grad_q  <= s_grad_q;
      end else begin
        o_spike_q <= p_spike;
        o_grad_q  <= p_grad;
      end
    end else if (en) begin
      s_spike_q <= p_spike;
      s_grad_q  <= p_grad;
    end
  end

  assign out_o.valid          = o_valid_q;
  assign out_o.spike          = o_spike_q;
  assign out_o.surrogate_grad = o_grad_q;

  `SSG_ASSERT(a_skid_needs_out, clk_i, rst_ni, s_valid_q |-> o_valid_q)
  `SSG_ASSERT(a_skid_fill, clk_i, rst_ni, $rose(s_valid_q) |-> $past(o_valid_q && !out_o.ready))
  `SSG_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, s_valid_q && out_o.ready, !s_valid_q)

endmodule
